// File: rtl/svrhs_pkg.sv
// Shared types, constants and saturation helpers for the staggered-grid
// y-momentum right-hand-side block. No dependencies.
`default_nettype none

package svrhs_pkg;

    localparam int ColW  = 10;
    localparam int RowW  = 16;
    localparam int ValW  = 48;
    localparam int UW    = 47;
    localparam int AddrW = ColW + 1;

    localparam logic [ValW-1:0] MaxPos = 48'h7FFF_FFFF_FFFF;
    localparam logic [ValW-1:0] MinNeg = 48'h8000_0000_0000;

    localparam logic [2:0] CfgRowCells   = 3'd0;
    localparam logic [2:0] CfgRowCount   = 3'd1;
    localparam logic [2:0] CfgImplicitX  = 3'd2;
    localparam logic [2:0] CfgImplicitY  = 3'd3;
    localparam logic [2:0] CfgDiffusivity = 3'd4;
    localparam logic [2:0] CfgGridDy     = 3'd5;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic            start;
        alu_op_t         op;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } alu_req_t;

    function automatic logic [ValW+1:0] ext50(input logic [ValW-1:0] x);
        return {{2{x[ValW-1]}}, x};
    endfunction

    function automatic logic [ValW-1:0] sat50(input logic [ValW+1:0] v);
        if ((v[ValW+1] == v[ValW]) && (v[ValW] == v[ValW-1]))
        begin
            return v[ValW-1:0];
        end
        return v[ValW+1] ? MinNeg : MaxPos;
    endfunction

endpackage

`default_nettype wire

// File: rtl/svrhs_alu.sv
// Iterative fixed-point unit: Q16.32 multiply (shift-add, one bit a cycle)
// and divide (restoring, one bit a cycle), both saturating. Uses svrhs_pkg.
`default_nettype none

module svrhs_alu (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire svrhs_pkg::alu_req_t            req,
    output logic                                done,
    output logic [svrhs_pkg::ValW-1:0]          result
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_MRES,
        A_DIV,
        A_DRES,
        A_OUT
    } alu_state_t;

    alu_state_t  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [47:0] ub_reg, ub_next;
    logic [96:0] prod_reg, prod_next;
    logic [48:0] rem_reg, rem_next;
    logic [79:0] num_reg, num_next;
    logic [46:0] q_reg, q_next;
    logic        ovf_reg, ovf_next;
    logic [47:0] res_reg, res_next;

    logic [47:0] mag_a;
    logic [47:0] mag_b;
    logic [48:0] mul_sum;
    logic [48:0] rem_shift;
    logic        rem_ge;

    function automatic logic [47:0] mag48(input logic [47:0] x);
        return x[47] ? (48'd0 - x) : x;
    endfunction

    function automatic logic [47:0] sat_mag(input logic neg, input logic big,
                                           input logic [46:0] m);
        if (!neg)
        begin
            return big ? svrhs_pkg::MaxPos : {1'b0, m};
        end
        return big ? svrhs_pkg::MinNeg : (48'd0 - {1'b0, m});
    endfunction

    assign mag_a     = mag48(req.a);
    assign mag_b     = mag48(req.b);
    assign mul_sum   = prod_reg[96:48] + (prod_reg[0] ? {1'b0, ub_reg} : 49'd0);
    assign rem_shift = {rem_reg[47:0], num_reg[79]};
    assign rem_ge    = rem_shift >= {1'b0, ub_reg};

    assign done   = (state_reg == A_OUT);
    assign result = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ub_next    = ub_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        res_next   = res_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = req.a[47] ^ req.b[47];
                    cnt_next = 7'd0;
                    if (req.op == svrhs_pkg::ALU_MUL)
                    begin
                        ub_next    = mag_a;
                        prod_next  = {49'd0, mag_b};
                        state_next = A_MUL;
                    end
                    else if (req.b == 48'd0)
                    begin
                        if (req.a == 48'd0)
                        begin
                            res_next = 48'd0;
                        end
                        else
                        begin
                            res_next = req.a[47] ? svrhs_pkg::MinNeg : svrhs_pkg::MaxPos;
                        end
                        state_next = A_OUT;
                    end
                    else
                    begin
                        ub_next    = mag_b;
                        num_next   = {mag_a, 32'd0};
                        rem_next   = 49'd0;
                        q_next     = 47'd0;
                        ovf_next   = 1'b0;
                        state_next = A_DIV;
                    end
                end
            end
            A_MUL:
            begin
                prod_next = {1'b0, mul_sum, prod_reg[47:1]};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd47)
                begin
                    state_next = A_MRES;
                end
            end
            A_MRES:
            begin
                res_next   = sat_mag(neg_reg, |prod_reg[95:79], prod_reg[78:32]);
                state_next = A_OUT;
            end
            A_DIV:
            begin
                rem_next = rem_ge ? (rem_shift - {1'b0, ub_reg}) : rem_shift;
                num_next = {num_reg[78:0], 1'b0};
                q_next   = {q_reg[45:0], rem_ge};
                ovf_next = ovf_reg | q_reg[46];
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd79)
                begin
                    state_next = A_DRES;
                end
            end
            A_DRES:
            begin
                res_next   = sat_mag(neg_reg, ovf_reg, q_reg);
                state_next = A_OUT;
            end
            A_OUT:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ub_reg   <= ub_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// File: rtl/staggered_vmomentum_rhs_stencil_top.sv
// Top level of the streamed y-momentum right-hand-side stencil: line stores,
// raster counters, step sequencer and output register. Uses svrhs_pkg, svrhs_alu.
//
//  channel  | handshake                  | contents
//  ---------+----------------------------+-----------------------------------------
//  item     | item_valid, item_stall     | velocities, pressure, spacing, frame_start
//  result   | result_valid, result_stall | explicit/implicit terms, cell position, last
//  cfg      | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// A node that yields no result is only written into the line stores. A node that
// yields a result is read, written, then run through the shared unit for 9 divides
// and 8 multiplies and summed; a zero divisor skips the iterations of a divide.
// A new node is accepted while a finished transfer waits on the result side. Reset
// returns configuration registers to their defaults and the raster position to zero.
`default_nettype none

module staggered_vmomentum_rhs_stencil_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [svrhs_pkg::ValW-1:0]    x_velocity,
    input  wire logic [svrhs_pkg::ValW-1:0]    y_velocity,
    input  wire logic [svrhs_pkg::ValW-1:0]    pressure,
    input  wire logic [svrhs_pkg::UW-1:0]      face_spacing,
    input  wire logic [svrhs_pkg::UW-1:0]      cell_width,
    input  wire logic                          frame_start,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [svrhs_pkg::ValW-1:0]         explicit_term,
    output logic [svrhs_pkg::ValW-1:0]         implicit_term,
    output logic [svrhs_pkg::ColW-1:0]         cell_column,
    output logic [svrhs_pkg::RowW-1:0]         cell_row,
    output logic                               frame_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [svrhs_pkg::UW-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_READ,
        T_WRITE,
        T_CALC,
        T_WAIT,
        T_SUM
    } top_state_t;

    typedef enum logic [4:0] {
        ST_DXM, ST_DXP, ST_DYM, ST_DYP, ST_CXM, ST_CXP,
        ST_T1, ST_M1, ST_T2, ST_M2, ST_A1, ST_A2,
        ST_KX, ST_DFX, ST_KY, ST_DFY, ST_PRE
    } step_t;

    top_state_t state_reg;
    step_t      step_reg;
    logic [2:0] rd_cnt_reg;
    logic       emit_reg;

    logic [9:0]  row_cells_reg;
    logic [15:0] row_count_reg;
    logic        implicit_x_reg;
    logic        implicit_y_reg;
    logic [46:0] diffusivity_reg;
    logic [46:0] grid_dy_reg;

    logic [9:0]  col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [9:0]  c_reg;
    logic [15:0] r_reg;
    logic        last_reg;

    logic [47:0] ux_in_reg, uy_in_reg, p_in_reg;
    logic [46:0] fs_reg, cw_reg, fs_r_reg;
    logic [47:0] uy_c_reg, uy_l_reg, uy_r_reg, uy_d_reg;
    logic [47:0] ux_cc_reg, ux_pc_reg, ux_cr_reg, ux_pr_reg;
    logic [47:0] p_pc_reg, p_cc_reg;
    logic [47:0] dxm_reg, dxp_reg, dym_reg, dyp_reg, cxm_reg, cxp_reg;
    logic [47:0] tmp_reg, advx_reg, advy_reg, difx_reg, dify_reg, pre_reg;

    logic [47:0] yv_mem [0:2047];
    logic [47:0] xv_mem [0:2047];
    logic [47:0] pv_mem [0:2047];
    logic [46:0] fc_mem [0:1023];
    logic [47:0] yv_rd_reg, xv_rd_reg, pv_rd_reg;
    logic [46:0] fc_rd_reg;
    logic [10:0] yv_addr, xv_addr, pv_addr;
    logic        mem_we;

    logic [47:0] explicit_reg, implicit_reg;
    logic [9:0]  out_col_reg;
    logic [15:0] out_row_reg;
    logic        out_last_reg;
    logic        out_valid_reg;

    svrhs_pkg::alu_req_t alu_req;
    logic                alu_done;
    logic [47:0]         alu_result;

    logic        accept;
    logic [9:0]  cells;
    logic [15:0] rows;
    logic [10:0] row_len;
    logic [16:0] last_row;
    logic [9:0]  c0;
    logic [15:0] r0;
    logic [10:0] c_inc;
    logic        emit0;
    logic        cur_bank, prv_bank;
    logic [9:0]  c_dec, c_up;
    logic [48:0] uxm_sum, uxp_sum, uym_sum, uyp_sum;
    logic [47:0] uxm, uxp, uym, uyp;
    logic [49:0] ex_sum, im_sum;

    function automatic logic [47:0] sub_sat(input logic [47:0] a, input logic [47:0] b);
        return svrhs_pkg::sat50(svrhs_pkg::ext50(a) - svrhs_pkg::ext50(b));
    endfunction

    svrhs_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .done   (alu_done),
        .result (alu_result)
    );

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != T_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign explicit_term = explicit_reg;
    assign implicit_term = implicit_reg;
    assign cell_column  = out_col_reg;
    assign cell_row     = out_row_reg;
    assign frame_last   = out_last_reg;

    always_comb
    begin
        cells = row_cells_reg;
        if (row_cells_reg == 10'd0)
        begin
            cells = 10'd1;
        end
        else if (row_cells_reg == 10'd1023)
        begin
            cells = 10'd1022;
        end
        rows = row_count_reg;
        if (row_count_reg == 16'd0)
        begin
            rows = 16'd1;
        end
        else if (row_count_reg > 16'd65533)
        begin
            rows = 16'd65533;
        end
        row_len  = {1'b0, cells} + 11'd2;
        last_row = {1'b0, rows} + 17'd1;
        c0 = frame_start ? 10'd0 : col_reg;
        r0 = frame_start ? 16'd0 : row_reg;
        if ({1'b0, c0} >= row_len)
        begin
            c0 = 10'd0;
        end
        emit0 = (c0 >= 10'd1) && (c0 <= cells) && (r0 >= 16'd2)
                && ({1'b0, r0} <= last_row);
        c_inc    = {1'b0, c0} + 11'd1;
        col_next = c_inc[9:0];
        row_next = r0;
        if (c_inc >= row_len)
        begin
            col_next = 10'd0;
            if (r0 != 16'hFFFF)
            begin
                row_next = r0 + 16'd1;
            end
        end
    end

    assign cur_bank = r_reg[0];
    assign prv_bank = ~r_reg[0];
    assign c_dec    = c_reg - 10'd1;
    assign c_up     = c_reg + 10'd1;
    assign mem_we   = (state_reg == T_WRITE);

    always_comb
    begin
        yv_addr = {prv_bank, c_reg};
        xv_addr = {cur_bank, c_reg};
        pv_addr = {prv_bank, c_reg};
        case (rd_cnt_reg)
            3'd1:
            begin
                yv_addr = {prv_bank, c_dec};
                xv_addr = {prv_bank, c_reg};
                pv_addr = {cur_bank, c_reg};
            end
            3'd2:
            begin
                yv_addr = {prv_bank, c_up};
                xv_addr = {cur_bank, c_up};
            end
            3'd3:
            begin
                yv_addr = {cur_bank, c_reg};
                xv_addr = {prv_bank, c_up};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            yv_mem[{cur_bank, c_reg}] <= uy_in_reg;
        end
        yv_rd_reg <= yv_mem[yv_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            xv_mem[{cur_bank, c_reg}] <= ux_in_reg;
        end
        xv_rd_reg <= xv_mem[xv_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pv_mem[{cur_bank, c_reg}] <= p_in_reg;
        end
        pv_rd_reg <= pv_mem[pv_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fc_mem[c_reg] <= fs_reg;
        end
        fc_rd_reg <= fc_mem[c_up];
    end

    assign uxm_sum = {ux_cc_reg[47], ux_cc_reg} + {ux_pc_reg[47], ux_pc_reg};
    assign uxp_sum = {ux_cr_reg[47], ux_cr_reg} + {ux_pr_reg[47], ux_pr_reg};
    assign uym_sum = {uy_d_reg[47], uy_d_reg} + {uy_c_reg[47], uy_c_reg};
    assign uyp_sum = {uy_c_reg[47], uy_c_reg} + {uy_in_reg[47], uy_in_reg};
    assign uxm     = uxm_sum[48:1];
    assign uxp     = uxp_sum[48:1];
    assign uym     = uym_sum[48:1];
    assign uyp     = uyp_sum[48:1];

    always_comb
    begin
        alu_req.start = (state_reg == T_CALC);
        alu_req.op    = svrhs_pkg::ALU_DIV;
        alu_req.a     = 48'd0;
        alu_req.b     = {1'b0, grid_dy_reg};
        case (step_reg)
            ST_DXM:
            begin
                alu_req.a = sub_sat(uy_c_reg, uy_l_reg);
                alu_req.b = {1'b0, fs_reg};
            end
            ST_DXP:
            begin
                alu_req.a = sub_sat(uy_r_reg, uy_c_reg);
                alu_req.b = {1'b0, fs_r_reg};
            end
            ST_DYM:
            begin
                alu_req.a = sub_sat(uy_c_reg, uy_d_reg);
            end
            ST_DYP:
            begin
                alu_req.a = sub_sat(uy_in_reg, uy_c_reg);
            end
            ST_CXM:
            begin
                alu_req.a = {1'b0, fs_reg};
                alu_req.b = {1'b0, cw_reg};
            end
            ST_CXP:
            begin
                alu_req.a = {1'b0, fs_r_reg};
                alu_req.b = {1'b0, cw_reg};
            end
            ST_T1:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = cxm_reg;
                alu_req.b  = uxm;
            end
            ST_M1:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = tmp_reg;
                alu_req.b  = dxm_reg;
            end
            ST_T2:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = cxp_reg;
                alu_req.b  = uxp;
            end
            ST_M2:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = tmp_reg;
                alu_req.b  = dxp_reg;
            end
            ST_A1:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = uym;
                alu_req.b  = dym_reg;
            end
            ST_A2:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = uyp;
                alu_req.b  = dyp_reg;
            end
            ST_KX:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = {1'b0, diffusivity_reg};
                alu_req.b  = sub_sat(dxp_reg, dxm_reg);
            end
            ST_DFX:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = {1'b0, cw_reg};
            end
            ST_KY:
            begin
                alu_req.op = svrhs_pkg::ALU_MUL;
                alu_req.a  = {1'b0, diffusivity_reg};
                alu_req.b  = sub_sat(dyp_reg, dym_reg);
            end
            ST_DFY:
            begin
                alu_req.a = tmp_reg;
            end
            ST_PRE:
            begin
                alu_req.a = sub_sat(p_pc_reg, p_cc_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign ex_sum = svrhs_pkg::ext50(advx_reg) + svrhs_pkg::ext50(advy_reg)
                  + (implicit_x_reg ? 50'd0 : svrhs_pkg::ext50(difx_reg))
                  + (implicit_y_reg ? 50'd0 : svrhs_pkg::ext50(dify_reg));
    assign im_sum = (implicit_x_reg ? svrhs_pkg::ext50(difx_reg) : 50'd0)
                  + (implicit_y_reg ? svrhs_pkg::ext50(dify_reg) : 50'd0)
                  + svrhs_pkg::ext50(pre_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            step_reg        <= ST_DXM;
            rd_cnt_reg      <= 3'd0;
            emit_reg        <= 1'b0;
            col_reg         <= 10'd0;
            row_reg         <= 16'd0;
            out_valid_reg   <= 1'b0;
            row_cells_reg   <= 10'd1022;
            row_count_reg   <= 16'd1022;
            implicit_x_reg  <= 1'b0;
            implicit_y_reg  <= 1'b0;
            diffusivity_reg <= 47'h1_0000_0000;
            grid_dy_reg     <= 47'h1_0000_0000;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    svrhs_pkg::CfgRowCells:    row_cells_reg   <= cfg_data[9:0];
                    svrhs_pkg::CfgRowCount:    row_count_reg   <= cfg_data[15:0];
                    svrhs_pkg::CfgImplicitX:   implicit_x_reg  <= cfg_data[0];
                    svrhs_pkg::CfgImplicitY:   implicit_y_reg  <= cfg_data[0];
                    svrhs_pkg::CfgDiffusivity: diffusivity_reg <= cfg_data;
                    svrhs_pkg::CfgGridDy:      grid_dy_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == T_SUM) && (!out_valid_reg || !result_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        col_reg    <= col_next;
                        row_reg    <= row_next;
                        emit_reg   <= emit0;
                        rd_cnt_reg <= 3'd0;
                        state_reg  <= emit0 ? T_READ : T_WRITE;
                    end
                end
                T_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg == 3'd4)
                    begin
                        state_reg <= T_WRITE;
                    end
                end
                T_WRITE:
                begin
                    step_reg  <= ST_DXM;
                    state_reg <= emit_reg ? T_CALC : T_IDLE;
                end
                T_CALC:
                begin
                    state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (alu_done)
                    begin
                        if (step_reg == ST_PRE)
                        begin
                            state_reg <= T_SUM;
                        end
                        else
                        begin
                            step_reg  <= step_t'(step_reg + 5'd1);
                            state_reg <= T_CALC;
                        end
                    end
                end
                T_SUM:
                begin
                    if (!out_valid_reg || !result_stall)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ux_in_reg <= x_velocity;
            uy_in_reg <= y_velocity;
            p_in_reg  <= pressure;
            fs_reg    <= face_spacing;
            cw_reg    <= cell_width;
            c_reg     <= c0;
            r_reg     <= r0;
            last_reg  <= (c0 == cells) && ({1'b0, r0} == last_row);
        end
        if (state_reg == T_READ)
        begin
            case (rd_cnt_reg)
                3'd1:
                begin
                    uy_c_reg  <= yv_rd_reg;
                    ux_cc_reg <= xv_rd_reg;
                    p_pc_reg  <= pv_rd_reg;
                    fs_r_reg  <= fc_rd_reg;
                end
                3'd2:
                begin
                    uy_l_reg  <= yv_rd_reg;
                    ux_pc_reg <= xv_rd_reg;
                    p_cc_reg  <= pv_rd_reg;
                end
                3'd3:
                begin
                    uy_r_reg  <= yv_rd_reg;
                    ux_cr_reg <= xv_rd_reg;
                end
                3'd4:
                begin
                    uy_d_reg  <= yv_rd_reg;
                    ux_pr_reg <= xv_rd_reg;
                end
                default:
                begin
                end
            endcase
        end
        if ((state_reg == T_WAIT) && alu_done)
        begin
            case (step_reg)
                ST_DXM: dxm_reg <= alu_result;
                ST_DXP: dxp_reg <= alu_result;
                ST_DYM: dym_reg <= alu_result;
                ST_DYP: dyp_reg <= alu_result;
                ST_CXM: cxm_reg <= {alu_result[47], alu_result[47:1]};
                ST_CXP: cxp_reg <= {alu_result[47], alu_result[47:1]};
                ST_T1:  tmp_reg <= alu_result;
                ST_M1:  advx_reg <= alu_result;
                ST_T2:  tmp_reg <= alu_result;
                ST_M2:
                begin
                    advx_reg <= svrhs_pkg::sat50(50'd0 - svrhs_pkg::ext50(advx_reg)
                                                 - svrhs_pkg::ext50(alu_result));
                end
                ST_A1:  advy_reg <= alu_result;
                ST_A2:
                begin
                    advy_reg <= svrhs_pkg::sat50(
                        50'd0 - svrhs_pkg::ext50({advy_reg[47], advy_reg[47:1]})
                        - svrhs_pkg::ext50({alu_result[47], alu_result[47:1]}));
                end
                ST_KX:  tmp_reg <= alu_result;
                ST_DFX: difx_reg <= alu_result;
                ST_KY:  tmp_reg <= alu_result;
                ST_DFY: dify_reg <= alu_result;
                ST_PRE:
                begin
                    pre_reg <= svrhs_pkg::sat50(50'd0 - svrhs_pkg::ext50(alu_result));
                end
                default:
                begin
                end
            endcase
        end
        if ((state_reg == T_SUM) && (!out_valid_reg || !result_stall))
        begin
            explicit_reg <= svrhs_pkg::sat50(ex_sum);
            implicit_reg <= svrhs_pkg::sat50(im_sum);
            out_col_reg  <= c_reg;
            out_row_reg  <= r_reg - 16'd1;
            out_last_reg <= last_reg;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_staggered_vmomentum_rhs_stencil_top.sv
// Self-checking testbench for staggered_vmomentum_rhs_stencil_top with a scoreboard
// class that predicts each interior cell's right-hand-side terms.
// Depends on svrhs_pkg and the RTL of the block.
module tb_staggered_vmomentum_rhs_stencil_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MaxP = 64'sh7FFF_FFFF_FFFF;
    localparam longint MinN = -64'sh8000_0000_0000;
    localparam int StallLimit = 20000;

    class rhs_scoreboard;
        typedef struct {
            longint ex;
            longint im;
            int     col;
            int     row;
            bit     last;
        } cell_terms_t;

        cell_terms_t pending[$];
        longint      uy_rows[2048];
        longint      ux_rows[2048];
        longint      p_rows[2048];
        longint      face_row[1024];
        int unsigned cells_reg;
        int unsigned rows_reg;
        int unsigned col_pos;
        int unsigned row_pos;
        bit          imp_x;
        bit          imp_y;
        longint      kappa;
        longint      dy;
        int          errors;

        function new();
            cells_reg = 1022;
            rows_reg = 1022;
            imp_x = 0;
            imp_y = 0;
            kappa = 64'sh1_0000_0000;
            dy = 64'sh1_0000_0000;
            col_pos = 0;
            row_pos = 0;
            errors = 0;
            foreach (uy_rows[i])
            begin
                uy_rows[i] = 0;
                ux_rows[i] = 0;
                p_rows[i] = 0;
            end
            foreach (face_row[i])
            begin
                face_row[i] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [svrhs_pkg::UW-1:0] d);
            case (idx)
                svrhs_pkg::CfgRowCells: cells_reg = d[svrhs_pkg::ColW-1:0];
                svrhs_pkg::CfgRowCount: rows_reg = d[svrhs_pkg::RowW-1:0];
                svrhs_pkg::CfgImplicitX: imp_x = d[0];
                svrhs_pkg::CfgImplicitY: imp_y = d[0];
                svrhs_pkg::CfgDiffusivity: kappa = longint'({17'd0, d});
                svrhs_pkg::CfgGridDy: dy = longint'({17'd0, d});
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > MaxP)
            begin
                return MaxP;
            end
            if (v < MinN)
            begin
                return MinN;
            end
            return v;
        endfunction

        function longint unsigned mag(longint a);
            longint unsigned m;
            m = a;
            return a < 0 ? -m : m;
        endfunction

        function longint signed_clip(bit neg, longint unsigned m);
            if (!neg)
            begin
                return m > 64'h7FFF_FFFF_FFFF ? MaxP : longint'(m);
            end
            if (m >= 64'h8000_0000_0000)
            begin
                return MinN;
            end
            return -longint'(m);
        endfunction

        function longint qmul(longint a, longint b);
            bit                neg;
            longint unsigned   ua;
            longint unsigned   ub;
            longint unsigned   hh;
            neg = (a < 0) != (b < 0);
            ua = mag(a);
            ub = mag(b);
            hh = (ua >> 32) * (ub >> 32);
            if (hh >= 64'h8000)
            begin
                return signed_clip(neg, 64'd1 << 48);
            end
            return signed_clip(neg, (hh << 32) + (ua >> 32) * ub[31:0]
                               + ua[31:0] * (ub >> 32) + ((ua[31:0] * ub[31:0]) >> 32));
        endfunction

        function longint qdiv(longint a, longint b);
            longint unsigned ua;
            longint unsigned ub;
            longint unsigned qi;
            longint unsigned rem;
            longint unsigned frac;
            bit              neg;
            if (b == 0)
            begin
                return a > 0 ? MaxP : (a < 0 ? MinN : 0);
            end
            neg = (a < 0) != (b < 0);
            ua = mag(a);
            ub = mag(b);
            qi = ua / ub;
            rem = ua % ub;
            frac = 0;
            if (qi >= 64'h8000)
            begin
                return signed_clip(neg, 64'd1 << 48);
            end
            for (int k = 0; k < 32; k++)
            begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= ub)
                begin
                    rem = rem - ub;
                    frac = frac | 1;
                end
            end
            return signed_clip(neg, (qi << 32) | frac);
        endfunction

        function void note_node(longint uxv, longint uyv, longint pv, longint fs, longint cw,
                                bit fst);
            int unsigned cells;
            int unsigned rows;
            int unsigned c;
            int unsigned r;
            int unsigned cur;
            int unsigned prv;
            longint      uy_c;
            longint      uy_l;
            longint      uy_r;
            longint      uy_d;
            longint      fs_r;
            longint      dxm;
            longint      dxp;
            longint      dym;
            longint      dyp;
            longint      advx;
            longint      advy;
            longint      difx;
            longint      dify;
            longint      pre;
            cell_terms_t t;
            cells = cells_reg < 1 ? 1 : (cells_reg > 1022 ? 1022 : cells_reg);
            rows = rows_reg < 1 ? 1 : (rows_reg > 65533 ? 65533 : rows_reg);
            if (fst)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= cells + 2)
            begin
                col_pos = 0;
            end
            c = col_pos;
            r = row_pos;
            cur = (r & 1) * 1024;
            prv = ((r + 1) & 1) * 1024;
            if (c >= 1 && c <= cells && r >= 2 && r <= rows + 1)
            begin
                uy_c = uy_rows[prv + c];
                uy_l = uy_rows[prv + c - 1];
                uy_r = uy_rows[prv + c + 1];
                uy_d = uy_rows[cur + c];
                fs_r = face_row[c + 1];
                dxm = qdiv(clip(uy_c - uy_l), fs);
                dxp = qdiv(clip(uy_r - uy_c), fs_r);
                dym = qdiv(clip(uy_c - uy_d), dy);
                dyp = qdiv(clip(uyv - uy_c), dy);
                advx = clip(-qmul(qmul(qdiv(fs, cw) >>> 1,
                                       (ux_rows[cur + c] + ux_rows[prv + c]) >>> 1), dxm)
                            - qmul(qmul(qdiv(fs_r, cw) >>> 1,
                                        (ux_rows[cur + c + 1] + ux_rows[prv + c + 1]) >>> 1),
                                   dxp));
                advy = clip(-(qmul((uy_d + uy_c) >>> 1, dym) >>> 1)
                            - (qmul((uy_c + uyv) >>> 1, dyp) >>> 1));
                difx = qdiv(qmul(kappa, clip(dxp - dxm)), cw);
                dify = qdiv(qmul(kappa, clip(dyp - dym)), dy);
                pre = clip(-qdiv(clip(p_rows[prv + c] - p_rows[cur + c]), dy));
                t.ex = clip(advx + advy + (imp_x ? 0 : difx) + (imp_y ? 0 : dify));
                t.im = clip((imp_x ? difx : 0) + (imp_y ? dify : 0) + pre);
                t.col = c;
                t.row = r - 1;
                t.last = (c == cells && r == rows + 1);
                pending.push_back(t);
            end
            uy_rows[cur + c] = uyv;
            ux_rows[cur + c] = uxv;
            p_rows[cur + c] = pv;
            face_row[c] = fs;
            col_pos = c + 1;
            if (col_pos >= cells + 2)
            begin
                col_pos = 0;
                if (row_pos < 65535)
                begin
                    row_pos++;
                end
            end
        endfunction

        function void check_result(logic [svrhs_pkg::ValW-1:0] ex,
                                   logic [svrhs_pkg::ValW-1:0] im,
                                   logic [svrhs_pkg::ColW-1:0] col,
                                   logic [svrhs_pkg::RowW-1:0] row, logic last);
            cell_terms_t t;
            if (pending.size() == 0)
            begin
                $display("%0t: result transfer with none expected", $realtime);
                errors++;
                return;
            end
            t = pending.pop_front();
            if (ex !== t.ex[svrhs_pkg::ValW-1:0])
            begin
                $display("%0t: explicit_term expected %h actual %h", $realtime,
                         t.ex[svrhs_pkg::ValW-1:0], ex);
                errors++;
            end
            if (im !== t.im[svrhs_pkg::ValW-1:0])
            begin
                $display("%0t: implicit_term expected %h actual %h", $realtime,
                         t.im[svrhs_pkg::ValW-1:0], im);
                errors++;
            end
            if (col !== t.col[svrhs_pkg::ColW-1:0])
            begin
                $display("%0t: cell_column expected %0d actual %0d", $realtime, t.col, col);
                errors++;
            end
            if (row !== t.row[svrhs_pkg::RowW-1:0])
            begin
                $display("%0t: cell_row expected %0d actual %0d", $realtime, t.row, row);
                errors++;
            end
            if (last !== t.last)
            begin
                $display("%0t: frame_last expected %0b actual %0b", $realtime, t.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_stall;
    logic [svrhs_pkg::ValW-1:0]   x_velocity;
    logic [svrhs_pkg::ValW-1:0]   y_velocity;
    logic [svrhs_pkg::ValW-1:0]   pressure;
    logic [svrhs_pkg::UW-1:0]     face_spacing;
    logic [svrhs_pkg::UW-1:0]     cell_width;
    logic                         frame_start;
    logic                         result_valid;
    logic                         result_stall;
    logic [svrhs_pkg::ValW-1:0]   explicit_term;
    logic [svrhs_pkg::ValW-1:0]   implicit_term;
    logic [svrhs_pkg::ColW-1:0]   cell_column;
    logic [svrhs_pkg::RowW-1:0]   cell_row;
    logic                         frame_last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [2:0]                   cfg_index;
    logic [svrhs_pkg::UW-1:0]     cfg_data;

    rhs_scoreboard sb;
    int            send_idle_pct;
    int            stall_pct;
    int            quiet_cycles = 0;
    int            nodes_sent;

    staggered_vmomentum_rhs_stencil_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .x_velocity   (x_velocity),
        .y_velocity   (y_velocity),
        .pressure     (pressure),
        .face_spacing (face_spacing),
        .cell_width   (cell_width),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .explicit_term(explicit_term),
        .implicit_term(implicit_term),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && item_valid && !item_stall)
        begin
            sb.note_node(longint'($signed(x_velocity)), longint'($signed(y_velocity)),
                         longint'($signed(pressure)), longint'({17'd0, face_spacing}),
                         longint'({17'd0, cell_width}), frame_start);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(explicit_term, implicit_term, cell_column, cell_row, frame_last);
        end
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > StallLimit)
        begin
            $display("staggered_vmomentum_rhs_stencil_top regression: fail");
            $finish;
        end
    end

    function automatic logic [svrhs_pkg::ValW-1:0] pick_value();
        case ($urandom_range(15))
            0: return svrhs_pkg::MaxPos;
            1: return svrhs_pkg::MinNeg;
            2: return '0;
            3, 4, 5: return 48'({$urandom, $urandom});
            default: return 48'(longint'($urandom) * 8 - 64'sh4_0000_0000);
        endcase
    endfunction

    function automatic logic [svrhs_pkg::UW-1:0] pick_span();
        case ($urandom_range(19))
            0: return '0;
            1: return {svrhs_pkg::UW{1'b1}};
            2: return 47'd1;
            3, 4: return 47'({$urandom, $urandom});
            default: return 47'(64'h8000_0000 + longint'($urandom));
        endcase
    endfunction

    task automatic set_reg(logic [2:0] idx, logic [svrhs_pkg::UW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_node(logic [svrhs_pkg::ValW-1:0] ux, logic [svrhs_pkg::ValW-1:0] uy,
                             logic [svrhs_pkg::ValW-1:0] p, logic [svrhs_pkg::UW-1:0] fs,
                             logic [svrhs_pkg::UW-1:0] cw, logic fst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        x_velocity <= ux;
        y_velocity <= uy;
        pressure <= p;
        face_spacing <= fs;
        cell_width <= cw;
        frame_start <= fst;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        nodes_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic stream_frame(int cells, int rows, int cut, bit noisy);
        int n;
        bit fst;
        n = 0;
        for (int r = 0; r < rows + 2; r++)
        begin
            for (int c = 0; c < cells + 2; c++)
            begin
                if (n < cut)
                begin
                    fst = (r == 0 && c == 0) || (noisy && $urandom_range(49) == 0);
                    push_node(pick_value(), pick_value(), pick_value(), pick_span(),
                              pick_span(), fst);
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        int phase_nodes;
        int cells;
        int rows;
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        x_velocity = '0;
        y_velocity = '0;
        pressure = '0;
        face_spacing = '0;
        cell_width = '0;
        frame_start = 1'b0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = svrhs_pkg::CfgRowCells;
        cfg_data = '0;
        nodes_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_reg(svrhs_pkg::CfgRowCells, 47'd2);
        set_reg(svrhs_pkg::CfgRowCount, 47'd2);
        set_reg(svrhs_pkg::CfgImplicitX, 47'd1);
        set_reg(svrhs_pkg::CfgImplicitY, 47'd0);
        set_reg(svrhs_pkg::CfgDiffusivity, {svrhs_pkg::UW{1'b1}});
        set_reg(svrhs_pkg::CfgGridDy, 47'h1_0000_0000);
        for (int n = 0; n < 16; n++)
        begin
            push_node(n[0] ? svrhs_pkg::MaxPos : svrhs_pkg::MinNeg,
                      n[1] ? svrhs_pkg::MaxPos : svrhs_pkg::MinNeg,
                      n[2] ? svrhs_pkg::MaxPos : '0,
                      n[3] ? {svrhs_pkg::UW{1'b1}} : 47'd1,
                      n[0] ? 47'd1 : {svrhs_pkg::UW{1'b1}}, n == 0);
        end
        drain();

        set_reg(svrhs_pkg::CfgRowCells, 47'd0);
        set_reg(svrhs_pkg::CfgRowCount, 47'd0);
        set_reg(svrhs_pkg::CfgImplicitY, 47'd1);
        set_reg(svrhs_pkg::CfgDiffusivity, 47'd0);
        set_reg(svrhs_pkg::CfgGridDy, 47'd0);
        for (int n = 0; n < 9; n++)
        begin
            push_node(pick_value(), n[0] ? 48'h1_0000_0000 : svrhs_pkg::MinNeg,
                      n[1] ? svrhs_pkg::MaxPos : svrhs_pkg::MinNeg,
                      '0, n[2] ? '0 : 47'h1_0000_0000, n == 0);
        end
        drain();

        set_reg(svrhs_pkg::CfgRowCells, 47'd1023);
        set_reg(svrhs_pkg::CfgRowCount, 47'hFFFF);
        set_reg(svrhs_pkg::CfgImplicitX, 47'd0);
        set_reg(svrhs_pkg::CfgImplicitY, 47'd0);
        set_reg(svrhs_pkg::CfgDiffusivity, 47'h1_0000_0000);
        set_reg(svrhs_pkg::CfgGridDy, {svrhs_pkg::UW{1'b1}});
        stream_frame(1022, 1, 150, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 82 : (phase == 3 ? 27 : 0);
            stall_pct = (phase == 2) ? 82 : (phase == 3 ? 27 : 0);
            for (int setting = 0; setting < 3; setting++)
            begin
                cells = $urandom_range(1, 6);
                rows = $urandom_range(1, 5);
                set_reg(svrhs_pkg::CfgRowCells, 47'(cells));
                set_reg(svrhs_pkg::CfgRowCount, 47'(rows));
                set_reg(svrhs_pkg::CfgImplicitX, 47'($urandom_range(1)));
                set_reg(svrhs_pkg::CfgImplicitY, 47'($urandom_range(1)));
                set_reg(svrhs_pkg::CfgDiffusivity, setting == 0 ? pick_span()
                                                   : 47'(longint'($urandom) << 1));
                set_reg(svrhs_pkg::CfgGridDy, setting == 1 ? pick_span()
                                              : 47'(64'h8000_0000 + longint'($urandom)));
                phase_nodes = nodes_sent + 30;
                while (nodes_sent < phase_nodes)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        stream_frame(cells, rows + $urandom_range(1, 2),
                                     $urandom_range(1, (cells + 2) * (rows + 2)), 1'b1);
                    end
                    else
                    begin
                        stream_frame(cells, rows, (cells + 2) * (rows + 2), 1'b0);
                    end
                end
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("staggered_vmomentum_rhs_stencil_top regression: pass");
        end
        else
        begin
            $display("staggered_vmomentum_rhs_stencil_top regression: fail");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/svrhs_pkg.sv
rtl/svrhs_alu.sv
rtl/staggered_vmomentum_rhs_stencil_top.sv
verif/tb_staggered_vmomentum_rhs_stencil_top.sv
